// ===== src/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
// Holds the command codes, register indexes and the pixel result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

  localparam int PIX_BITS     = 12;
  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int COLOR_BITS   = 8;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [PIX_BITS-1:0] px;
    logic [PIX_BITS-1:0] py;
    logic                on_image;
    logic                last;
  } pix_res_t;

endpackage

`default_nettype wire

// ===== src/line_rasterizer_unit.sv =====
// Bresenham line rasterizer top level: line state, stepping and the on-image check.
// Depends on lr_pkg for command codes, register indexes and the result record.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   in       | in_valid / in_ready    | cmd, endpoints, color, flags
//   out      | out_valid / out_ready  | pixel x/y, inside, color, blend, last
//   cfg      | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// An accepted item is held in an input register, then turned into results;
// a thin line gives one pixel per cycle unless the result side stalls, a thick
// line two pixels per item. A step while no line is active gives nothing.
// The result register and a one-entry neighbor slot decouple the two sides,
// so one item can wait in the input register while a result is stalled.
// Reset is synchronous and active low; it empties all stages.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_unit
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire                          clk,
  input  wire                          rst_n,

  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_cmd,
  input  wire signed [COORD_BITS-1:0]  in_start_x,
  input  wire signed [COORD_BITS-1:0]  in_start_y,
  input  wire signed [COORD_BITS-1:0]  in_end_x,
  input  wire signed [COORD_BITS-1:0]  in_end_y,
  input  wire        [COLOR_BITS-1:0]  in_red,
  input  wire        [COLOR_BITS-1:0]  in_green,
  input  wire        [COLOR_BITS-1:0]  in_blue,
  input  wire                          in_transparent,
  input  wire                          in_thick,

  output logic                         out_valid,
  input  wire                          out_ready,
  output logic       [PIX_BITS-1:0]    out_pixel_x,
  output logic       [PIX_BITS-1:0]    out_pixel_y,
  output logic                         out_inside_res,
  output logic       [COLOR_BITS-1:0]  out_red,
  output logic       [COLOR_BITS-1:0]  out_green,
  output logic       [COLOR_BITS-1:0]  out_blue,
  output logic                         out_blend,
  output logic                         out_line_last,

  input  wire                          cfg_we,
  input  wire        [CFG_IDX_BITS-1:0] cfg_index,
  input  wire        [CFG_BITS-1:0]    cfg_wdata
);

  localparam int CW = COORD_BITS;
  localparam int XW = CW + 1;
  localparam int TW = CW + 1;
  localparam int AW = CW + 2;
  localparam int EW = ((XW > PIX_BITS + 1) ? XW : PIX_BITS + 1) + 1;

  localparam logic signed [CW-1:0] ONE_C = CW'(1);
  localparam logic signed [XW-1:0] ONE_X = XW'(1);

  function automatic pix_res_t emit_px(input logic signed [XW-1:0] x,
                                       input logic signed [XW-1:0] y,
                                       input logic                 last,
                                       input logic [CFG_BITS-1:0]  w,
                                       input logic [CFG_BITS-1:0]  h);
    logic signed [EW-1:0] ix;
    logic signed [EW-1:0] iy;
    pix_res_t             r;
    ix = EW'(x) + EW'({1'b0, w[CFG_BITS-1:1]});
    iy = EW'(y) + EW'({1'b0, h[CFG_BITS-1:1]});
    r.px       = ix[PIX_BITS-1:0];
    r.py       = iy[PIX_BITS-1:0];
    r.on_image = !ix[EW-1] && (ix[EW-2:0] < (EW-1)'(w)) &&
                 !iy[EW-1] && (iy[EW-2:0] < (EW-1)'(h));
    r.last     = last;
    return r;
  endfunction

  logic [CFG_BITS-1:0] width_r, height_r;

  logic                   s1_v_r, s1_v_nxt;
  logic                   s1_cmd_r;
  logic signed [CW-1:0]   s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;
  logic [COLOR_BITS-1:0]  s1_red_r, s1_green_r, s1_blue_r;
  logic                   s1_transp_r, s1_thick_r;

  logic                   active_r, active_nxt;
  logic signed [CW-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [AW-1:0]          err_r, err_nxt;
  logic [TW-1:0]          tdx_r, tdx_nxt, tdy_r, tdy_nxt;
  logic [CW-1:0]          steps_r, steps_nxt;
  logic                   xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic                   xmaj_r, xmaj_nxt;
  logic [COLOR_BITS-1:0]  red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic                   transp_r, transp_nxt, thick_r, thick_nxt;

  logic                   out_v_r, out_v_nxt;
  pix_res_t               out_r, out_nxt;
  logic                   pend_v_r, pend_v_nxt;
  pix_res_t               pend_r, pend_nxt;

  logic                   in_fire, out_room, s1_fire;
  logic signed [XW-1:0]   dx, dy, adx_f, ady_f;
  logic [CW-1:0]          adx, ady, major;
  logic                   maj;
  logic [AW-1:0]          err_sum;
  logic [TW-1:0]          tmin, tmaj;
  logic signed [CW-1:0]   xs_c, ys_c, nx, ny;
  logic signed [XW-1:0]   xs_x, ys_x;
  logic                   last, thick;
  logic [1:0]             n_res;
  pix_res_t               main_px, nb_px;

  assign out_room = !out_v_r || out_ready;
  assign s1_fire  = s1_v_r && !pend_v_r && out_room;
  assign in_ready = !s1_v_r || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign s1_v_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_v_r);

  always_comb begin
    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    tdx_nxt    = tdx_r;
    tdy_nxt    = tdy_r;
    steps_nxt  = steps_r;
    xneg_nxt   = xneg_r;
    yneg_nxt   = yneg_r;
    xmaj_nxt   = xmaj_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    transp_nxt = transp_r;
    thick_nxt  = thick_r;

    dx    = XW'(s1_ex_r) - XW'(s1_sx_r);
    dy    = XW'(s1_ey_r) - XW'(s1_sy_r);
    adx_f = dx[XW-1] ? -dx : dx;
    ady_f = dy[XW-1] ? -dy : dy;
    adx   = adx_f[CW-1:0];
    ady   = ady_f[CW-1:0];
    maj   = adx >= ady;
    major = maj ? adx : ady;

    xs_c = xneg_r ? -ONE_C : ONE_C;
    ys_c = yneg_r ? -ONE_C : ONE_C;
    xs_x = xneg_r ? -ONE_X : ONE_X;
    ys_x = yneg_r ? -ONE_X : ONE_X;
    tmin = xmaj_r ? tdy_r : tdx_r;
    tmaj = xmaj_r ? tdx_r : tdy_r;
    err_sum = err_r + AW'(tmin);
    nx = cur_x_r;
    ny = cur_y_r;

    last    = 1'b0;
    thick   = thick_r;
    n_res   = 2'd0;
    main_px = emit_px(XW'(cur_x_r), XW'(cur_y_r), 1'b0, width_r, height_r);
    nb_px   = main_px;

    if (s1_cmd_r == CMD_START) begin
      xneg_nxt   = dx[XW-1];
      yneg_nxt   = dy[XW-1];
      tdx_nxt    = {adx, 1'b0};
      tdy_nxt    = {ady, 1'b0};
      xmaj_nxt   = maj;
      err_nxt    = AW'(major);
      steps_nxt  = major;
      cur_x_nxt  = s1_sx_r;
      cur_y_nxt  = s1_sy_r;
      red_nxt    = s1_red_r;
      green_nxt  = s1_green_r;
      blue_nxt   = s1_blue_r;
      transp_nxt = s1_transp_r;
      thick_nxt  = s1_thick_r;
      active_nxt = major != '0;
      last       = major == '0;
      thick      = s1_thick_r;
      n_res      = s1_thick_r ? 2'd2 : 2'd1;
      main_px = emit_px(XW'(s1_sx_r), XW'(s1_sy_r), last && !thick, width_r, height_r);
      nb_px   = emit_px(XW'(s1_sx_r) + ONE_X, XW'(s1_sy_r) + ONE_X, last,
                        width_r, height_r);
    end else if (active_r) begin
      if (xmaj_r) begin
        nx = cur_x_r + xs_c;
        if (err_sum > AW'(tmaj)) begin
          ny = cur_y_r + ys_c;
        end
      end else begin
        ny = cur_y_r + ys_c;
        if (err_sum > AW'(tmaj)) begin
          nx = cur_x_r + xs_c;
        end
      end
      err_nxt    = (err_sum > AW'(tmaj)) ? err_sum - AW'(tmaj) : err_sum;
      cur_x_nxt  = nx;
      cur_y_nxt  = ny;
      steps_nxt  = steps_r - ONE_C;
      active_nxt = steps_nxt != '0;
      last       = steps_nxt == '0;
      n_res      = thick_r ? 2'd2 : 2'd1;
      main_px = emit_px(XW'(nx), XW'(ny), last && !thick, width_r, height_r);
      nb_px   = emit_px(XW'(nx) + ys_x, XW'(ny) + xs_x, last, width_r, height_r);
    end
  end

  always_comb begin
    out_v_nxt  = out_v_r && !out_ready;
    out_nxt    = out_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (pend_v_r) begin
      if (out_room) begin
        out_v_nxt  = 1'b1;
        out_nxt    = pend_r;
        pend_v_nxt = 1'b0;
      end
    end else if (s1_fire) begin
      if (n_res != 2'd0) begin
        out_v_nxt = 1'b1;
        out_nxt   = main_px;
      end
      if (n_res == 2'd2) begin
        pend_v_nxt = 1'b1;
        pend_nxt   = nb_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      active_r <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      err_r    <= '0;
      tdx_r    <= '0;
      tdy_r    <= '0;
      steps_r  <= '0;
      xneg_r   <= 1'b0;
      yneg_r   <= 1'b0;
      xmaj_r   <= 1'b0;
      red_r    <= '0;
      green_r  <= '0;
      blue_r   <= '0;
      transp_r <= 1'b0;
      thick_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_IMAGE_HEIGHT) begin
        height_r <= cfg_wdata;
      end
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
      if (s1_fire) begin
        active_r <= active_nxt;
        cur_x_r  <= cur_x_nxt;
        cur_y_r  <= cur_y_nxt;
        err_r    <= err_nxt;
        tdx_r    <= tdx_nxt;
        tdy_r    <= tdy_nxt;
        steps_r  <= steps_nxt;
        xneg_r   <= xneg_nxt;
        yneg_r   <= yneg_nxt;
        xmaj_r   <= xmaj_nxt;
        red_r    <= red_nxt;
        green_r  <= green_nxt;
        blue_r   <= blue_nxt;
        transp_r <= transp_nxt;
        thick_r  <= thick_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
    if (in_fire) begin
      s1_cmd_r    <= in_cmd;
      s1_sx_r     <= in_start_x;
      s1_sy_r     <= in_start_y;
      s1_ex_r     <= in_end_x;
      s1_ey_r     <= in_end_y;
      s1_red_r    <= in_red;
      s1_green_r  <= in_green;
      s1_blue_r   <= in_blue;
      s1_transp_r <= in_transparent;
      s1_thick_r  <= in_thick;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pixel_x    = out_r.px;
  assign out_pixel_y    = out_r.py;
  assign out_inside_res = out_r.on_image;
  assign out_line_last  = out_r.last;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_blend      = transp_r;

endmodule

`default_nettype wire

// ===== src/lr_checker.sv =====
// Port-level assertions for the line rasterizer and the bind that attaches them.
// Sees only the top level's ports; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module lr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [11:0] out_pixel_x,
  input wire [11:0] out_pixel_y,
  input wire        out_line_last
);

  // No result can appear in the cycle after reset was held.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the result side empty, nothing may stall the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while no result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_x) && $stable(out_pixel_y) &&
      $stable(out_line_last))
    else $error("result payload changed while stalled");

endmodule

bind line_rasterizer_unit lr_checker u_lr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pixel_x   (out_pixel_x),
  .out_pixel_y   (out_pixel_y),
  .out_line_last (out_line_last)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the line rasterizer: directed lines, image size phases
// and random line sequences, every pixel checked against an in-bench Bresenham tracer.
// Depends on lr_pkg and line_rasterizer_unit.
`timescale 1ns / 1ps

module tb
  import lr_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       cmd;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [11:0] ex;
    logic [11:0] ey;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        transp;
    logic        thick;
  } line_item_t;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic        on_image;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        blend;
    logic        last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_cmd = CMD_START;
  logic signed [11:0]       in_start_x = '0;
  logic signed [11:0]       in_start_y = '0;
  logic signed [11:0]       in_end_x = '0;
  logic signed [11:0]       in_end_y = '0;
  logic [COLOR_BITS-1:0]    in_red = '0;
  logic [COLOR_BITS-1:0]    in_green = '0;
  logic [COLOR_BITS-1:0]    in_blue = '0;
  logic                     in_transparent = 1'b0;
  logic                     in_thick = 1'b0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [PIX_BITS-1:0]      out_pixel_x;
  logic [PIX_BITS-1:0]      out_pixel_y;
  logic                     out_inside_res;
  logic [COLOR_BITS-1:0]    out_red;
  logic [COLOR_BITS-1:0]    out_green;
  logic [COLOR_BITS-1:0]    out_blue;
  logic                     out_blend;
  logic                     out_line_last;

  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_BITS-1:0]      cfg_wdata = '0;

  pixel_t pending_pixels[$];
  int     errors = 0;
  int     cycles = 0;
  bit     no_idle = 1'b0;

  int          img_w;
  int          img_h;
  bit          line_active;
  int          pos_x;
  int          pos_y;
  int          err_sum;
  int          dbl_dx;
  int          dbl_dy;
  int          steps_remaining;
  bit          step_neg_x;
  bit          step_neg_y;
  bit          major_is_x;
  logic [23:0] line_rgb;
  logic [1:0]  line_mode;

  line_rasterizer_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_transparent (in_transparent),
    .in_thick       (in_thick),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_inside_res (out_inside_res),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_blend      (out_blend),
    .out_line_last  (out_line_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 17);
  end

  function automatic string pixel_str(pixel_t p);
    return $sformatf("x=%0d y=%0d inside=%0d rgb=%0d,%0d,%0d blend=%0d last=%0d",
                     p.px, p.py, p.on_image, p.red, p.green, p.blue, p.blend, p.last);
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = {out_pixel_x, out_pixel_y, out_inside_res, out_red, out_green, out_blue,
             out_blend, out_line_last};
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t tb: unexpected pixel, expected none, actual %s", $time, pixel_str(got));
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t tb: pixel mismatch, expected %s, actual %s",
                   $time, pixel_str(want), pixel_str(got));
        end
      end
    end
  end

  function automatic void clear_tracer();
    img_w = int'(IMAGE_WIDTH_RST);
    img_h = int'(IMAGE_HEIGHT_RST);
    line_active = 1'b0;
    pos_x = 0;
    pos_y = 0;
    err_sum = 0;
    dbl_dx = 0;
    dbl_dy = 0;
    steps_remaining = 0;
    step_neg_x = 1'b0;
    step_neg_y = 1'b0;
    major_is_x = 1'b0;
    line_rgb = '0;
    line_mode = '0;
  endfunction

  function automatic void push_pixel(int x, int y, bit last);
    int     ix;
    int     iy;
    pixel_t p;
    ix = x + img_w / 2;
    iy = y + img_h / 2;
    p.px = ix[11:0];
    p.py = iy[11:0];
    p.on_image = (ix >= 0) && (ix < img_w) && (iy >= 0) && (iy < img_h);
    p.red = line_rgb[23:16];
    p.green = line_rgb[15:8];
    p.blue = line_rgb[7:0];
    p.blend = line_mode[0];
    p.last = last;
    pending_pixels.push_back(p);
  endfunction

  function automatic void trace_line(line_item_t c);
    int x0;
    int y0;
    int x1;
    int y1;
    int dx;
    int dy;
    int xs;
    int ys;
    x0 = $signed(c.sx);
    y0 = $signed(c.sy);
    x1 = $signed(c.ex);
    y1 = $signed(c.ey);
    if (c.cmd == CMD_START) begin
      dx = x1 - x0;
      dy = y1 - y0;
      step_neg_x = dx < 0;
      step_neg_y = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      dbl_dx = 2 * dx;
      dbl_dy = 2 * dy;
      major_is_x = dbl_dx >= dbl_dy;
      err_sum = major_is_x ? dx : dy;
      steps_remaining = major_is_x ? dx : dy;
      pos_x = x0;
      pos_y = y0;
      line_rgb = {c.red, c.green, c.blue};
      line_mode = {c.thick, c.transp};
      line_active = steps_remaining > 0;
      push_pixel(pos_x, pos_y, !line_active && !line_mode[1]);
      if (line_mode[1]) push_pixel(pos_x + 1, pos_y + 1, !line_active);
    end else if (line_active) begin
      xs = step_neg_x ? -1 : 1;
      ys = step_neg_y ? -1 : 1;
      if (major_is_x) begin
        pos_x += xs;
        err_sum += dbl_dy;
        if (err_sum > dbl_dx) begin
          pos_y += ys;
          err_sum -= dbl_dx;
        end
      end else begin
        pos_y += ys;
        err_sum += dbl_dx;
        if (err_sum > dbl_dy) begin
          pos_x += xs;
          err_sum -= dbl_dy;
        end
      end
      steps_remaining -= 1;
      line_active = steps_remaining > 0;
      push_pixel(pos_x, pos_y, !line_active && !line_mode[1]);
      if (line_mode[1]) push_pixel(pos_x + ys, pos_y + xs, !line_active);
    end
  endfunction

  function automatic line_item_t line_start(int x0, int y0, int x1, int y1,
                                            logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic tr, logic th);
    line_item_t it;
    it.cmd = CMD_START;
    it.sx = x0[11:0];
    it.sy = y0[11:0];
    it.ex = x1[11:0];
    it.ey = y1[11:0];
    it.red = r;
    it.green = g;
    it.blue = b;
    it.transp = tr;
    it.thick = th;
    return it;
  endfunction

  function automatic line_item_t line_step();
    line_item_t it;
    it = line_start(int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)),
                    int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)),
                    8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    it.cmd = CMD_STEP;
    return it;
  endfunction

  task automatic send_item(input line_item_t it);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_start_x <= it.sx;
    in_start_y <= it.sy;
    in_end_x <= it.ex;
    in_end_y <= it.ey;
    in_red <= it.red;
    in_green <= it.green;
    in_blue <= it.blue;
    in_transparent <= it.transp;
    in_thick <= it.thick;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    trace_line(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_w = val & 'hFFF;
    else img_h = val & 'hFFF;
  endtask

  task automatic set_image(input int w, input int h);
    drain_results();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  function automatic int pick_start();
    if ($urandom_range(99) < 50) return int'($urandom_range(0, 48)) - 24;
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int pick_end(int p, int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    if (p + d > 2047 || p + d < -2048) d = -d;
    return p + d;
  endfunction

  task automatic random_line(output int n_sent);
    int r;
    int span;
    int x0;
    int y0;
    int x1;
    int y1;
    int adx;
    int ady;
    int planned;
    r = $urandom_range(99);
    span = (r < 6) ? 2047 : ((r < 30) ? 40 : 6);
    x0 = pick_start();
    y0 = pick_start();
    x1 = pick_end(x0, span);
    y1 = pick_end(y0, span);
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    planned = (adx > ady) ? adx : ady;
    if (r < 20) planned = $urandom_range(0, (planned < 5) ? planned : 5);
    send_item(line_start(x0, y0, x1, y1, 8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom), 1'($urandom)));
    repeat (planned) send_item(line_step());
    n_sent = planned + 1;
    if ($urandom_range(9) == 0) send_item(line_step());
  endtask

  task automatic run_random(input int n);
    int total;
    int got;
    total = 0;
    while (total < n) begin
      if ($urandom_range(99) < 6) send_item(line_step());
      random_line(got);
      total += got;
    end
  endtask

  task automatic test_directed();
    send_item(line_step());
    send_item(line_start(0, 0, 0, 0, 8'd255, 8'd0, 8'd255, 1'b1, 1'b0));
    send_item(line_start(-2048, -2048, -2048, -2048, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
    send_item(line_start(2047, 2047, 2045, 2046, 8'd0, 8'd255, 8'd0, 1'b0, 1'b1));
    repeat (2) send_item(line_step());
    send_item(line_start(-2048, 2047, -2047, 2044, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    repeat (4) send_item(line_step());
    send_item(line_start(10, -5, 13, -5, 8'd12, 8'd34, 8'd56, 1'b0, 1'b0));
    send_item(line_step());
    send_item(line_start(0, 0, -2, 2, 8'd200, 8'd100, 8'd50, 1'b1, 1'b1));
    repeat (2) send_item(line_step());
    send_item(line_start(5, 3, 5, -1, 8'd1, 8'd2, 8'd3, 1'b0, 1'b1));
    repeat (5) send_item(line_step());
  endtask

  task automatic test_image_sizes();
    set_image(1, 1);
    run_random(45);
    set_image(2048, 2048);
    run_random(45);
    set_image(2048, 1);
    run_random(45);
    set_image(1, 2048);
    run_random(45);
    set_image(int'($urandom_range(1, 2048)), int'($urandom_range(1, 2048)));
    run_random(45);
    set_image(640, 480);
    run_random(45);
  endtask

  task automatic test_full_rate();
    no_idle = 1'b1;
    run_random(40);
    drain_results();
    run_random(20);
    no_idle = 1'b0;
    run_random(20);
  endtask

  initial begin
    clear_tracer();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_image_sizes();
    test_full_rate();
    drain_results();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
